@@ design/base64_stream_decoder_unit_assert.svh @@
// Assertion macros shared by the base64 stream decoder modules.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define B64D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("b64d assertion failed");
`define B64D_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("b64d reset assertion failed");
`else
`define B64D_ASSERT(lbl, prop)
`define B64D_ASSERT_RST(lbl, prop)
`endif

`endif

@@ design/b64d_pkg.sv @@
// Types, status codes and the character lookup for the base64 stream decoder.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic [1:0]      status;
    logic            msg_end;
  } grp_t;

  // bit 6 set: character outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = ch - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      d = ch - 8'h61 + 8'd26;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30 + 8'd52;
    end else if (ch == 8'h2B) begin
      d = 8'd62;
    end else if (ch == 8'h2F) begin
      d = 8'd63;
    end else begin
      d = 8'd64;
    end
    return d[6:0];
  endfunction

endpackage

@@ design/base64_stream_decoder_unit.sv @@
// Each accepted character is held in the input register; its results go to the result register.
// Throughput: one character per cycle unless the input stalls; a completed group sends out
//   up to three bytes, one per cycle unless stalled, while new characters keep coming.
// The input register stalls only when a character with results meets a full result register.
// Reset (rst_ni low, asynchronous) clears group state, dropping mode and the valid state of both registers.
`include "base64_stream_decoder_unit_assert.svh"

module base64_stream_decoder_unit import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_char_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       run_last_o,
  output logic       message_end_o
);

  logic       vld_q;
  logic [7:0] char_q;
  logic       eot_q;
  grp_t       res;
  logic       free;
  logic       go;
  logic       accept;

  assign go         = vld_q && ((res.cnt == 2'd0) || free);
  assign in_stall_o = vld_q && !go;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (go) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= text_char_i;
      eot_q  <= end_of_text_i;
    end
  end

  b64d_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (go),
    .text_char_i   (char_q),
    .end_of_text_i (eot_q),
    .res_o         (res)
  );

  b64d_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (go && (res.cnt != 2'd0)),
    .grp_i         (res),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

endmodule

@@ design/b64d_decode.sv @@
// Group state and per-character decode into a result group.
`include "base64_stream_decoder_unit_assert.svh"

module b64d_decode import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  logic [7:0] text_char_i,
  input  logic       end_of_text_i,
  output grp_t       res_o
);

  logic [17:0] store_q, store_d;
  logic [1:0]  pos_q, pos_d;
  logic        inv_q, inv_d;
  logic        third_pad_q, third_pad_d;
  logic        drop_q, drop_d;

  logic        pad;
  logic [6:0]  sx;
  logic [5:0]  v;
  logic        bad;
  logic        inv_n;
  logic [23:0] triple;

  always_comb begin
    pad    = (text_char_i == PAD_CHAR);
    sx     = sextet_of(text_char_i);
    v      = sx[5:0];
    bad    = sx[6];
    if (pos_q[1] && pad) begin
      v   = 6'd0;
      bad = 1'b0;
    end else if (bad) begin
      v = 6'd0;
    end
    inv_n  = inv_q | bad;
    triple = {store_q, v};

    store_d     = store_q;
    pos_d       = pos_q;
    inv_d       = inv_q;
    third_pad_d = third_pad_q;
    drop_d      = drop_q;

    res_o.cnt     = 2'd0;
    res_o.bytes   = '0;
    res_o.status  = ST_DATA;
    res_o.msg_end = end_of_text_i;

    if (drop_q) begin
      if (end_of_text_i) begin
        drop_d = 1'b0;
      end
    end else if (pos_q != 2'd3) begin
      if (end_of_text_i) begin
        res_o.cnt    = 2'd1;
        res_o.status = ST_LENGTH;
        store_d      = '0;
        pos_d        = 2'd0;
        inv_d        = 1'b0;
        third_pad_d  = 1'b0;
      end else begin
        store_d     = {store_q[11:0], v};
        pos_d       = pos_q + 2'd1;
        inv_d       = inv_n;
        third_pad_d = third_pad_q | ((pos_q == 2'd2) && pad);
      end
    end else begin
      store_d     = '0;
      pos_d       = 2'd0;
      inv_d       = 1'b0;
      third_pad_d = 1'b0;
      if (inv_n) begin
        res_o.cnt    = 2'd1;
        res_o.status = ST_INVALID;
        drop_d       = !end_of_text_i;
      end else begin
        res_o.bytes[0] = triple[23:16];
        case ({third_pad_q, pad})
          2'b00: begin
            res_o.cnt      = 2'd3;
            res_o.bytes[1] = triple[15:8];
            res_o.bytes[2] = triple[7:0];
          end
          2'b01: begin
            res_o.cnt      = 2'd2;
            res_o.bytes[1] = triple[15:8];
          end
          2'b10: begin
            res_o.cnt      = 2'd2;
            res_o.bytes[1] = triple[7:0];
          end
          default: begin
            res_o.cnt = 2'd1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q     <= '0;
      pos_q       <= 2'd0;
      inv_q       <= 1'b0;
      third_pad_q <= 1'b0;
      drop_q      <= 1'b0;
    end else if (go_i) begin
      store_q     <= store_d;
      pos_q       <= pos_d;
      inv_q       <= inv_d;
      third_pad_q <= third_pad_d;
      drop_q      <= drop_d;
    end
  end

  `B64D_ASSERT(a_drop_group_clear, drop_q |-> (pos_q == 2'd0 && !inv_q && !third_pad_q))
  `B64D_ASSERT(a_error_single, (res_o.cnt != 2'd0 && res_o.status != ST_DATA) |-> res_o.cnt == 2'd1)
  `B64D_ASSERT(a_pad_flag_pos, third_pad_q |-> pos_q == 2'd3)

endmodule

@@ design/b64d_out_buf.sv @@
// Result register that holds one decoded group and sends it out one request at a time.
`include "base64_stream_decoder_unit_assert.svh"

module b64d_out_buf import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  grp_t       grp_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       run_last_o,
  output logic       message_end_o
);

  logic [1:0]      cnt_q, cnt_d;
  logic [2:0][7:0] bytes_q, bytes_d;
  logic [1:0]      status_q;
  logic            msg_end_q;
  logic            take;

  assign out_valid_o   = (cnt_q != 2'd0);
  assign take          = out_valid_o && !out_stall_i;
  assign free_o        = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);
  assign out_byte_o    = bytes_q[0];
  assign status_o      = status_q;
  assign run_last_o    = (cnt_q == 2'd1);
  assign message_end_o = msg_end_q;

  always_comb begin
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    if (load_i) begin
      cnt_d   = grp_i.cnt;
      bytes_d = grp_i.bytes;
    end else if (take) begin
      cnt_d   = cnt_q - 2'd1;
      bytes_d = {8'd0, bytes_q[2], bytes_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    if (load_i) begin
      status_q  <= grp_i.status;
      msg_end_q <= grp_i.msg_end;
    end
  end

  `B64D_ASSERT(a_load_when_free, load_i |-> free_o)
  `B64D_ASSERT(a_drain_empty, (take && cnt_q == 2'd1 && !load_i) |=> cnt_q == 2'd0)
  `B64D_ASSERT_RST(a_reset_empty, !rst_ni |=> cnt_q == 2'd0 || rst_ni)

endmodule

@@ verif/base64_stream_decoder_unit_tb.sv @@
// Randomized self-checking testbench for the base64 stream decoder unit.
`timescale 1ns / 1ps

module base64_stream_decoder_unit_tb;
  import b64d_pkg::*;

  localparam int CHAR_TARGET = 410;
  localparam int CALM_FROM   = 360;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
    logic       msg_end;
  } decoded_t;

  class char_decode_model;
    logic [17:0] sextets;
    logic [1:0]  grp_pos;
    logic        grp_bad;
    logic        third_pad;
    logic        dropping;
    decoded_t    pending_bytes[$];
    int          errors;
    int          live_chars;

    function new();
      clear_message();
      errors = 0;
      live_chars = 0;
    endfunction

    function void clear_message();
      sextets = '0;
      grp_pos = '0;
      grp_bad = 1'b0;
      third_pad = 1'b0;
      dropping = 1'b0;
    endfunction

    function void push(logic [7:0] data, logic [1:0] st, logic last, logic mend);
      decoded_t r;
      r.data = data;
      r.status = st;
      r.last = last;
      r.msg_end = mend;
      pending_bytes = {pending_bytes, r};
    endfunction

    function void note_char(logic [7:0] ch, logic eot);
      logic [5:0]  v;
      logic        pad;
      logic [23:0] triple;
      pad = (ch == PAD_CHAR);
      v = '0;
      if (dropping) begin
        if (eot) clear_message();
        return;
      end
      live_chars++;
      if (ch inside {[8'h41:8'h5A]}) begin
        v = 6'(ch - 8'h41);
      end else if (ch inside {[8'h61:8'h7A]}) begin
        v = 6'(ch - 8'h61 + 8'd26);
      end else if (ch inside {[8'h30:8'h39]}) begin
        v = 6'(ch - 8'h30 + 8'd52);
      end else if (ch == 8'h2B) begin
        v = 6'd62;
      end else if (ch == 8'h2F) begin
        v = 6'd63;
      end else if (!(pad && grp_pos >= 2'd2)) begin
        grp_bad = 1'b1;
      end
      if (grp_pos != 2'd3) begin
        if (grp_pos == 2'd2 && pad) third_pad = 1'b1;
        sextets = {sextets[11:0], v};
        grp_pos = grp_pos + 2'd1;
        if (eot) begin
          push(8'h00, ST_LENGTH, 1'b1, 1'b1);
          clear_message();
        end
        return;
      end
      if (grp_bad) begin
        push(8'h00, ST_INVALID, 1'b1, eot);
        clear_message();
        dropping = !eot;
        return;
      end
      triple = {sextets, v};
      push(triple[23:16], ST_DATA, third_pad && pad, eot);
      if (!third_pad) push(triple[15:8], ST_DATA, pad, eot);
      if (!pad) push(triple[7:0], ST_DATA, 1'b1, eot);
      clear_message();
    endfunction

    function void check_byte(logic [7:0] data, logic [1:0] st, logic last, logic mend);
      decoded_t want;
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h status %0d", data, st);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (last !== want.last) begin
        $error("run_last: expected %0b, got %0b", want.last, last);
        errors++;
      end
      if (mend !== want.msg_end) begin
        $error("message_end: expected %0b, got %0b", want.msg_end, mend);
        errors++;
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] text_char_i;
  logic       end_of_text_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic       run_last_o;
  logic       message_end_o;

  char_decode_model sb;
  logic [7:0] msg_q[$];
  logic       calm;
  logic       in_busy;
  int         cycles;

  base64_stream_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stall the output in random bursts; quiet stretches come from out_busy.
  initial begin
    int  stall_left;
    int  span;
    logic out_busy;
    stall_left = 0;
    span = 0;
    out_busy = 1'b1;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        span = $urandom_range(16, 80);
        out_busy = ($urandom_range(0, 2) != 0);
      end
      span--;
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (!calm && out_busy && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_byte(out_byte_o, status_o, run_last_o, message_end_o);
    end
  end

  function automatic logic [7:0] alpha_char(int idx);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    if (idx == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic void append_char(input logic [7:0] ch);
    msg_q = {msg_q, ch};
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic eot);
    int gap;
    gap = 0;
    if (!calm && in_busy && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_char_i <= ch;
    end_of_text_i <= eot;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    sb.note_char(ch, eot);
    @(posedge clk_i);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) begin
      send_char(msg_q[i], i == msg_q.size() - 1);
    end
    msg_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  // Hold the sender until every outstanding request has drained.
  task automatic drain_hold();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic build_random_message();
    int groups;
    int padsel;
    int len;
    int r;
    if ($urandom_range(0, 9) < 8) begin
      groups = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
      for (int g = 0; g < groups; g++) begin
        for (int k = 0; k < 4; k++) append_char(alpha_char($urandom_range(0, 63)));
        padsel = (g == groups - 1) ? $urandom_range(0, 3) :
                 (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
        if (padsel == 1 || padsel == 2) msg_q[msg_q.size() - 1] = PAD_CHAR;
        if (padsel == 2 || padsel == 3) msg_q[msg_q.size() - 2] = PAD_CHAR;
      end
    end else begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (r < 5) append_char(alpha_char($urandom_range(0, 63)));
        else if (r < 7) append_char(PAD_CHAR);
        else append_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic paused_mid;
    sb = new();
    paused_mid = 1'b0;
    calm = 1'b0;
    in_busy = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    text_char_i = 8'h00;
    end_of_text_i = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_text("TQ==+/9z");
    send_message();
    add_text("TW=u");
    send_message();
    add_text("TWE=");
    send_message();
    append_char(PAD_CHAR);
    append_char(8'h00);
    append_char(8'h41);
    append_char(8'hFF);
    add_text("Zza");
    send_message();
    add_text("TWE");
    send_message();
    drain_hold();

    while (sb.live_chars < CHAR_TARGET) begin
      if (!paused_mid && sb.live_chars >= CHAR_TARGET / 2) begin
        paused_mid = 1'b1;
        drain_hold();
      end
      calm = (sb.live_chars >= CALM_FROM);
      in_busy = ($urandom_range(0, 2) != 0);
      build_random_message();
      send_message();
    end

    drain_hold();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
